/* hdl/mbdc_pkg.sv */
`timescale 1ns / 1ps

package mbdc_pkg;

    // Sizes
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int SCALE_SHIFT     = 16;
    localparam int CFG_W           = 16;
    localparam int CFG_IDX_W       = 2;

    // Register reset values
    localparam logic [15:0] TICKS_RESET      = 16'd1000;
    localparam logic [2:0]  MODE_HOLD_RESET  = 3'd2;
    localparam logic [2:0]  REPEAT_RESET     = 3'd1;
    localparam logic [15:0] VOLT_SCALE_RESET = 16'd5280;

    // Limits
    localparam logic [2:0] HOLD_MAX  = 3'd7;
    localparam logic [3:0] DIGIT_MAX = 4'd9;
    localparam logic [9:0] VOLT_MAX  = 10'd999;

    typedef enum logic [1:0] {
        CFG_TICKS      = 2'd0,
        CFG_MODE_HOLD  = 2'd1,
        CFG_REPEAT     = 2'd2,
        CFG_VOLT_SCALE = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_STOPWATCH = 2'd0,
        MODE_MANUAL    = 2'd1,
        MODE_VOLT      = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    typedef struct packed {
        logic [15:0] ticks;
        logic [2:0]  mode_hold;
        logic [2:0]  repeat_sec;
        logic [15:0] volt_scale;
    } cfg_t;

    typedef struct packed {
        logic [3:0] hundreds;
        logic [3:0] tens;
        logic [3:0] units;
    } digits_t;

    typedef struct packed {
        logic tick;
        logic reset_btn;
        logic plus_btn;
        logic minus_btn;
    } item_t;

    typedef struct packed {
        digits_t digits;
        mode_t   mode;
    } disp_t;

    // Seven-segment pattern, bit0 A through bit6 G; blank above nine
    function automatic logic [6:0] seg_of(input logic [3:0] d);
        logic [6:0] s;
        unique case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h67;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

    // Increment, 999 wraps to 000
    function automatic digits_t bcd_up(input digits_t d);
        digits_t r;
        r = d;
        if (d.units < DIGIT_MAX) begin
            r.units = d.units + 4'd1;
        end else begin
            r.units = 4'd0;
            if (d.tens < DIGIT_MAX) begin
                r.tens = d.tens + 4'd1;
            end else begin
                r.tens = 4'd0;
                if (d.hundreds < DIGIT_MAX) begin
                    r.hundreds = d.hundreds + 4'd1;
                end else begin
                    r.hundreds = 4'd0;
                end
            end
        end
        return r;
    endfunction

    // Decrement, 000 wraps to 999
    function automatic digits_t bcd_down(input digits_t d);
        digits_t r;
        r = d;
        if (d.units != 4'd0) begin
            r.units = d.units - 4'd1;
        end else begin
            r.units = DIGIT_MAX;
            if (d.tens != 4'd0) begin
                r.tens = d.tens - 4'd1;
            end else begin
                r.tens = DIGIT_MAX;
                if (d.hundreds != 4'd0) begin
                    r.hundreds = d.hundreds - 4'd1;
                end else begin
                    r.hundreds = DIGIT_MAX;
                end
            end
        end
        return r;
    endfunction

    function automatic digits_t bcd_step(input digits_t d, input dir_t dir);
        digits_t r;
        unique case (dir)
            DIR_UP:   r = bcd_up(d);
            DIR_DOWN: r = bcd_down(d);
            default:  r = d;
        endcase
        return r;
    endfunction

    // Plus wins over minus
    function automatic dir_t active_of(input logic plus_btn, input logic minus_btn);
        dir_t r;
        priority if (plus_btn) begin
            r = DIR_UP;
        end else if (minus_btn) begin
            r = DIR_DOWN;
        end else begin
            r = DIR_NONE;
        end
        return r;
    endfunction

endpackage

/* hdl/multimode_bcd_display_counter_core.sv */
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// config    cfg_we                cfg_index, cfg_data
// input     in_valid / in_stall   tick, reset_button, plus_button, minus_button, adc_sample
// output    out_valid / out_stall digits, mode, segment patterns, point_hundreds
//
// One item per cycle sustained while the output is not stalled; a taken item passes
// through the input register (sample times scale multiplier), then through the state
// update into the display registers.
// Reset clears mode, digits and counters; registers return to their defaults.
// A stalled result holds both stages; the input side stalls only when both are full.

module multimode_bcd_display_counter_core
    import mbdc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   tick,
    input  logic                   reset_button,
    input  logic                   plus_button,
    input  logic                   minus_button,
    input  logic [SAMPLE_BITS-1:0] adc_sample,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [3:0]             units_out,
    output logic [3:0]             tens_out,
    output logic [3:0]             hundreds_out,
    output logic [1:0]             mode_out,
    output logic [6:0]             seg_units,
    output logic [6:0]             seg_tens,
    output logic [6:0]             seg_hundreds,
    output logic [6:0]             seg_mode,
    output logic                   point_hundreds
);

    localparam int PW = SAMPLE_BITS + SCALE_SHIFT;

    cfg_t          cfg;
    logic          take;
    logic          item_vld;
    item_t         item;
    logic [PW-1:0] product;
    digits_t       volt_digits;
    disp_t         disp;

    mbdc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mbdc_in_stage #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_in (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .tick         (tick),
        .reset_button (reset_button),
        .plus_button  (plus_button),
        .minus_button (minus_button),
        .adc_sample   (adc_sample),
        .volt_scale   (cfg.volt_scale),
        .take         (take),
        .item_vld     (item_vld),
        .item         (item),
        .product      (product)
    );

    mbdc_volt #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_volt (
        .product (product),
        .digits  (volt_digits)
    );

    mbdc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .item_vld    (item_vld),
        .item        (item),
        .volt_digits (volt_digits),
        .take        (take),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .disp        (disp)
    );

    // Drive digits, mode, their segment patterns and the hundreds point
    assign units_out      = disp.digits.units;
    assign tens_out       = disp.digits.tens;
    assign hundreds_out   = disp.digits.hundreds;
    assign mode_out       = disp.mode;
    assign seg_units      = seg_of(disp.digits.units);
    assign seg_tens       = seg_of(disp.digits.tens);
    assign seg_hundreds   = seg_of(disp.digits.hundreds);
    assign seg_mode       = seg_of({2'b00, disp.mode});
    assign point_hundreds = (disp.mode == MODE_VOLT);

endmodule

/* hdl/mbdc_cfg_regs.sv */
`timescale 1ns / 1ps

module mbdc_cfg_regs
    import mbdc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TICKS:      cfg_next.ticks      = cfg_data;
                CFG_MODE_HOLD:  cfg_next.mode_hold  = cfg_data[2:0];
                CFG_REPEAT:     cfg_next.repeat_sec = cfg_data[2:0];
                CFG_VOLT_SCALE: cfg_next.volt_scale = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks      <= TICKS_RESET;
            cfg_reg.mode_hold  <= MODE_HOLD_RESET;
            cfg_reg.repeat_sec <= REPEAT_RESET;
            cfg_reg.volt_scale <= VOLT_SCALE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/mbdc_in_stage.sv */
`timescale 1ns / 1ps

module mbdc_in_stage
    import mbdc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          tick,
    input  logic                          reset_button,
    input  logic                          plus_button,
    input  logic                          minus_button,
    input  logic [SAMPLE_BITS-1:0]        adc_sample,
    input  logic [15:0]                   volt_scale,
    input  logic                          take,
    output logic                          item_vld,
    output item_t                         item,
    output logic [SAMPLE_BITS+SCALE_SHIFT-1:0] product
);

    localparam int PW = SAMPLE_BITS + SCALE_SHIFT;

    logic          vld_reg;
    logic          vld_next;
    logic          load;
    item_t         item_reg;
    logic [PW-1:0] product_reg;
    logic [PW-1:0] product_next;

    // Hold while the core cannot take the item
    assign in_stall = vld_reg && !take;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        priority if (load)
        begin
            vld_next = 1'b1;
        end
        else if (take)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    // Scale the sample on the way in
    assign product_next = PW'(adc_sample) * PW'(volt_scale);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg    <= '{tick: tick, reset_btn: reset_button,
                             plus_btn: plus_button, minus_btn: minus_button};
            product_reg <= product_next;
        end
    end

    assign item_vld = vld_reg;
    assign item     = item_reg;
    assign product  = product_reg;

endmodule

/* hdl/mbdc_volt.sv */
`timescale 1ns / 1ps

module mbdc_volt
    import mbdc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic [SAMPLE_BITS+SCALE_SHIFT-1:0] product,
    output digits_t                            digits
);

    localparam int PW = SAMPLE_BITS + SCALE_SHIFT;

    logic [SAMPLE_BITS-1:0] volts;
    logic [9:0]             val;
    logic [9:0]             rem_h;
    logic [9:0]             rem_t;
    logic [3:0]             hund;
    logic [3:0]             tens;

    assign volts = product[PW-1:SCALE_SHIFT];

    // Saturate at 999, then split into decimal digits by constant compares
    always_comb
    begin
        if (17'(volts) > 17'(VOLT_MAX))
        begin
            val = VOLT_MAX;
        end
        else
        begin
            val = 10'(volts);
        end

        hund  = 4'd0;
        rem_h = val;
        for (int k = 1; k <= 9; k++)
        begin
            if (val >= 10'(k * 100))
            begin
                hund  = 4'(k);
                rem_h = val - 10'(k * 100);
            end
        end

        tens  = 4'd0;
        rem_t = rem_h;
        for (int k = 1; k <= 9; k++)
        begin
            if (rem_h >= 10'(k * 10))
            begin
                tens  = 4'(k);
                rem_t = rem_h - 10'(k * 10);
            end
        end

        digits.hundreds = hund;
        digits.tens     = tens;
        digits.units    = rem_t[3:0];
    end

endmodule

/* hdl/mbdc_core.sv */
`timescale 1ns / 1ps

module mbdc_core
    import mbdc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    item_vld,
    input  item_t   item,
    input  digits_t volt_digits,
    output logic    take,
    output logic    out_valid,
    input  logic    out_stall,
    output disp_t   disp
);

    logic [15:0] sub_reg;
    logic [15:0] sub_next;
    logic [2:0]  hold_reg;
    logic [2:0]  hold_next;
    digits_t     digits_reg;
    digits_t     digits_next;
    mode_t       mode_reg;
    mode_t       mode_next;
    logic [2:0]  hist_reg;
    logic [2:0]  hist_next;
    logic        out_vld_reg;
    logic        out_vld_next;

    logic        prev_rb;
    dir_t        a_prev;
    dir_t        a_now;
    logic        clr;
    logic [15:0] sub0;
    logic [2:0]  hold0;
    logic [15:0] sub_inc;
    logic [15:0] sub_cnt;
    logic        sec;
    logic [2:0]  hold_inc;
    digits_t     d1;
    mode_t       mode_adv;

    // Take an item when the result register is free or being emptied
    assign take = item_vld && (!out_vld_reg || !out_stall);

    always_comb
    begin
        priority if (take)
        begin
            out_vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    // Shared pieces: press/release edges, second count, hold count, release step, next mode
    always_comb
    begin
        prev_rb = hist_reg[0];
        a_prev  = active_of(hist_reg[1], hist_reg[2]);
        a_now   = active_of(item.plus_btn, item.minus_btn);

        if (item.reset_btn)
        begin
            clr = !prev_rb;
        end
        else
        begin
            clr = prev_rb || (mode_reg == MODE_MANUAL && a_prev != a_now);
        end

        sub0     = clr ? 16'd0 : sub_reg;
        hold0    = clr ? 3'd0 : hold_reg;
        sub_inc  = sub0 + 16'd1;
        sec      = item.tick && (sub_inc >= cfg.ticks);
        sub_cnt  = item.tick ? (sec ? 16'd0 : sub_inc) : sub0;
        hold_inc = (hold0 == HOLD_MAX) ? HOLD_MAX : hold0 + 3'd1;
        d1       = (a_prev != a_now) ? bcd_step(digits_reg, a_prev) : digits_reg;

        unique case (mode_reg)
            MODE_STOPWATCH: mode_adv = MODE_MANUAL;
            MODE_MANUAL:    mode_adv = MODE_VOLT;
            default:        mode_adv = MODE_STOPWATCH;
        endcase
    end

    // Next state for one item
    always_comb
    begin
        sub_next    = sub_reg;
        hold_next   = hold_reg;
        digits_next = digits_reg;
        mode_next   = mode_reg;
        hist_next   = hist_reg;

        if (take)
        begin
            hist_next = {item.minus_btn, item.plus_btn, item.reset_btn};
            if (item.reset_btn)
            begin
                // Hold the digits at zero, count the hold towards a mode step
                digits_next = '0;
                sub_next    = sub_cnt;
                hold_next   = hold0;
                if (sec)
                begin
                    if (hold_inc >= cfg.mode_hold)
                    begin
                        mode_next = mode_adv;
                        hold_next = 3'd0;
                    end
                    else
                    begin
                        hold_next = hold_inc;
                    end
                end
            end
            else
            begin
                unique case (mode_reg)
                    MODE_STOPWATCH:
                    begin
                        sub_next  = sub_cnt;
                        hold_next = hold0;
                        if (sec)
                        begin
                            digits_next = bcd_up(digits_reg);
                        end
                    end
                    MODE_MANUAL:
                    begin
                        digits_next = d1;
                        if (a_now == DIR_NONE)
                        begin
                            sub_next  = 16'd0;
                            hold_next = 3'd0;
                        end
                        else
                        begin
                            sub_next  = sub_cnt;
                            hold_next = hold0;
                            if (sec)
                            begin
                                if (hold_inc >= cfg.repeat_sec)
                                begin
                                    digits_next = bcd_step(d1, a_now);
                                    hold_next   = 3'd0;
                                end
                                else
                                begin
                                    hold_next = hold_inc;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        // Voltmeter: counters hold apart from the release clear
                        sub_next    = sub0;
                        hold_next   = hold0;
                        digits_next = volt_digits;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg     <= '0;
            hold_reg    <= '0;
            digits_reg  <= '0;
            mode_reg    <= MODE_STOPWATCH;
            hist_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            sub_reg     <= sub_next;
            hold_reg    <= hold_next;
            digits_reg  <= digits_next;
            mode_reg    <= mode_next;
            hist_reg    <= hist_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // State moves only with the result, so it doubles as the result register
    assign out_valid   = out_vld_reg;
    assign disp.digits = digits_reg;
    assign disp.mode   = mode_reg;

endmodule
